/* sv/vmtp_pkg.sv */
// Package for the vector move-toward-point pipeline.
// Holds fixed widths shared by the interfaces and the datapath, and the speed reset value; no dependencies.
package vmtp_pkg;
	localparam int SPEED_WIDTH = 24;
	localparam int DT_WIDTH    = 20;
	localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 24'd800;
endpackage

/* sv/vmtp_if.sv */
// Valid/ready channels: input request, result, and speed register write.
// Width of coordinates is a parameter; depends on vmtp_pkg.
interface vmtp_in_if import vmtp_pkg::*; #(parameter int COORD_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z;
	logic [DT_WIDTH-1:0] delta_time;
	modport source (output valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, delta_time,
		input ready);
	modport sink (input valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, delta_time,
		output ready);
endinterface

interface vmtp_out_if #(parameter int COORD_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] next_x, next_y, next_z;
	logic snapped;
	modport source (output valid, next_x, next_y, next_z, snapped, input ready);
	modport sink (input valid, next_x, next_y, next_z, snapped, output ready);
endinterface

interface vmtp_cfg_if import vmtp_pkg::*; ();
	logic valid;
	logic ready;
	logic [SPEED_WIDTH-1:0] move_speed;
	modport source (output valid, move_speed, input ready);
	modport sink (input valid, move_speed, output ready);
endinterface

/* sv/vector_move_toward_point.sv */
// Path from request to result: differences, squares, sum, R = COORD_WIDTH+2 root stages, setup,
// Q = COORD_WIDTH quotient stages and the output register.
// Throughput: one request per cycle; the whole pipeline advances together, so a
// stalled result holds every stage. The root and divider resolve one bit per stage.
// Reset: arst_n clears valid bits and loads move_speed with 50.0 (800).
// Depends on vmtp_pkg and the channel interfaces in vmtp_if.sv.
module vector_move_toward_point import vmtp_pkg::*; #(
	parameter int COORD_WIDTH    = 24,
	parameter int TIME_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	vmtp_in_if.sink   in_ch,
	vmtp_out_if.source out_ch,
	vmtp_cfg_if.sink  cfg_ch
);
	localparam int CW  = COORD_WIDTH;
	localparam int MW  = CW + 1;           // |diff| width
	localparam int SW  = 2 * MW + 2;       // sum of squares width
	localparam int RW  = MW + 1;           // root width
	localparam int PW  = SPEED_WIDTH + DT_WIDTH;
	localparam int NW  = MW + CW - 1;      // mag*step width
	localparam int R   = RW;               // root stages
	localparam int Q   = CW;               // quotient bits (q <= step < 2^(CW-1))
	localparam logic [CW-2:0] CMAX = '1;

	typedef struct packed {
		logic signed [CW-1:0] cx, cy, cz, tx, ty, tz;
		logic [MW-1:0] mx, my, mz;
		logic          nx, ny, nz;
		logic [CW-2:0] step;
	} base_t;

	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;
	assign cfg_ch.ready = 1'b1;

	logic [SPEED_WIDTH-1:0] speed_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) speed_q <= SPEED_RESET;
		else if (cfg_ch.valid) speed_q <= cfg_ch.move_speed;
	end

	// stage 1: differences, magnitudes, step product
	logic v_s1;
	base_t b_s1;
	base_t b_n1;
	logic [PW-1:0] prod_s1;
	logic signed [CW:0] dx, dy, dz;
	always_comb begin
		dx = {in_ch.tgt_x[CW-1], in_ch.tgt_x} - {in_ch.cur_x[CW-1], in_ch.cur_x};
		dy = {in_ch.tgt_y[CW-1], in_ch.tgt_y} - {in_ch.cur_y[CW-1], in_ch.cur_y};
		dz = {in_ch.tgt_z[CW-1], in_ch.tgt_z} - {in_ch.cur_z[CW-1], in_ch.cur_z};
		b_n1.cx = in_ch.cur_x; b_n1.cy = in_ch.cur_y; b_n1.cz = in_ch.cur_z;
		b_n1.tx = in_ch.tgt_x; b_n1.ty = in_ch.tgt_y; b_n1.tz = in_ch.tgt_z;
		b_n1.nx = dx[CW]; b_n1.ny = dy[CW]; b_n1.nz = dz[CW];
		b_n1.mx = dx[CW] ? MW'(-dx) : MW'(dx);
		b_n1.my = dy[CW] ? MW'(-dy) : MW'(dy);
		b_n1.mz = dz[CW] ? MW'(-dz) : MW'(dz);
		b_n1.step = '0;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1 <= b_n1;
			prod_s1 <= PW'(speed_q) * PW'(in_ch.delta_time);
		end
	end

	// stage 2: squares, step shift and clamp
	logic v_s2;
	base_t b_s2;
	base_t b_n2;
	logic [2*MW-1:0] qx_s2, qy_s2, qz_s2;
	logic [PW-1:0] sh;
	assign sh = prod_s1 >> TIME_FRAC_BITS;
	always_comb begin
		b_n2 = b_s1;
		b_n2.step = (sh > PW'(CMAX)) ? CMAX : sh[CW-2:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s2 <= b_n2;
			qx_s2 <= (2*MW)'(b_s1.mx) * (2*MW)'(b_s1.mx);
			qy_s2 <= (2*MW)'(b_s1.my) * (2*MW)'(b_s1.my);
			qz_s2 <= (2*MW)'(b_s1.mz) * (2*MW)'(b_s1.mz);
		end
	end

	// stage 3: sum of squares
	logic v_s3;
	base_t b_s3;
	logic [SW-1:0] sum_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3 <= b_s2;
			sum_s3 <= SW'(qx_s2) + SW'(qy_s2) + SW'(qz_s2);
		end
	end

	// root: restoring, one bit per stage, MSB first
	logic           rv_s [R+1];
	base_t          rb_s [R+1];
	logic [SW-1:0]  rrem_s [R+1];   // remaining radicand bits
	logic [RW+1:0]  rr_s [R+1];     // partial remainder
	logic [RW-1:0]  rq_s [R+1];     // partial root
	assign rv_s[0] = v_s3;
	assign rb_s[0] = b_s3;
	assign rrem_s[0] = sum_s3;
	assign rr_s[0] = '0;
	assign rq_s[0] = '0;
	for (genvar i = 0; i < R; i++) begin : g_root
		logic [RW+1:0] t, c;
		always_comb begin
			t = {rr_s[i][RW-1:0], rrem_s[i][SW-1 -: 2]};
			c = {rq_s[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[i+1] <= 1'b0;
			else if (adv) rv_s[i+1] <= rv_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rb_s[i+1] <= rb_s[i];
				rrem_s[i+1] <= rrem_s[i] << 2;
				if (t >= c) begin
					rr_s[i+1] <= t - c;
					rq_s[i+1] <= {rq_s[i][RW-2:0], 1'b1};
				end else begin
					rr_s[i+1] <= t;
					rq_s[i+1] <= {rq_s[i][RW-2:0], 1'b0};
				end
			end
		end
	end

	// setup: snap decision and numerators
	logic v_d;
	base_t b_d;
	logic snap_d;
	logic [RW-1:0] len_d;
	logic [NW-1:0] nx_d, ny_d, nz_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d <= 1'b0;
		else if (adv) v_d <= rv_s[R];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b_d <= rb_s[R];
			len_d <= rq_s[R];
			snap_d <= (rq_s[R] == '0) || (rq_s[R] <= RW'(rb_s[R].step));
			nx_d <= NW'(rb_s[R].mx) * NW'(rb_s[R].step);
			ny_d <= NW'(rb_s[R].my) * NW'(rb_s[R].step);
			nz_d <= NW'(rb_s[R].mz) * NW'(rb_s[R].step);
		end
	end

	// divider: three lanes, one quotient bit per stage; q < 2^Q since q <= step
	typedef struct packed {
		logic [NW-1:0] r;
		logic [Q-1:0]  q;
	} lane_t;
	logic          dv_s [Q+1];
	base_t         db_s [Q+1];
	logic          dsn_s [Q+1];
	logic [RW-1:0] dl_s [Q+1];
	lane_t         dx_s [Q+1], dy_s [Q+1], dz_s [Q+1];
	assign dv_s[0] = v_d;
	assign db_s[0] = b_d;
	assign dsn_s[0] = snap_d;
	assign dl_s[0] = len_d;
	assign dx_s[0] = '{r: nx_d, q: '0};
	assign dy_s[0] = '{r: ny_d, q: '0};
	assign dz_s[0] = '{r: nz_d, q: '0};

	function automatic lane_t div_step(lane_t a, logic [RW-1:0] d, int k);
		logic [NW+Q-1:0] sd;
		lane_t o;
		sd = (NW+Q)'(d) << k;
		o = a;
		if ((NW+Q)'(a.r) >= sd) begin
			o.r = a.r - NW'(sd);
			o.q[k] = 1'b1;
		end
		return o;
	endfunction

	for (genvar j = 0; j < Q; j++) begin : g_div
		localparam int K = Q - 1 - j;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[j+1] <= 1'b0;
			else if (adv) dv_s[j+1] <= dv_s[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				db_s[j+1] <= db_s[j];
				dsn_s[j+1] <= dsn_s[j];
				dl_s[j+1] <= dl_s[j];
				dx_s[j+1] <= div_step(dx_s[j], dl_s[j], K);
				dy_s[j+1] <= div_step(dy_s[j], dl_s[j], K);
				dz_s[j+1] <= div_step(dz_s[j], dl_s[j], K);
			end
		end
	end

	// output register
	function automatic logic signed [CW-1:0] apply(logic signed [CW-1:0] c, logic neg,
		logic [Q-1:0] q);
		return neg ? c - CW'(q) : c + CW'(q);
	endfunction

	base_t fb;
	assign fb = db_s[Q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (adv) out_ch.valid <= dv_s[Q];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.snapped <= dsn_s[Q];
			out_ch.next_x <= dsn_s[Q] ? fb.tx : apply(fb.cx, fb.nx, dx_s[Q].q);
			out_ch.next_y <= dsn_s[Q] ? fb.ty : apply(fb.cy, fb.ny, dy_s[Q].q);
			out_ch.next_z <= dsn_s[Q] ? fb.tz : apply(fb.cz, fb.nz, dz_s[Q].q);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped under stall");
	a_snap_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.snapped |-> out_ch.next_x == $past(fb.tx) ||
		!$past(adv))
		else $error("snap does not give target");
	a_stall_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=>
		$stable({out_ch.next_x, out_ch.next_y, out_ch.next_z, out_ch.snapped}))
		else $error("result changed under stall");
endmodule
